FILE: src/touch_stroke_capture_core_macros.svh
// Assertion macros shared by the touch stroke capture checker.
`ifndef TOUCH_STROKE_CAPTURE_CORE_MACROS_SVH
`define TOUCH_STROKE_CAPTURE_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TSC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent after the delay written into the property.
`define TSC_ASSERT_AFTER2(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##2 (cons)) else $error(msg);

`endif

FILE: src/tsc_pkg.sv
// Constants and codes for the touch stroke capture core.
`default_nettype none

package tsc_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// field widths fixed by the item format
	localparam int TIME_W  = 32;
	localparam int WAIT_W  = 16;
	localparam int LIMIT_W = 4;
	localparam int DUR_W   = 16;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_WAIT = 2'd0,
		CFG_STROKE_CAP = 2'd1,
		CFG_MISS_LIMIT = 2'd2
	} cfg_reg_t;

	// item kinds
	typedef enum logic {
		OP_START = 1'b0,
		OP_POLL  = 1'b1
	} opcode_t;

	// register defaults
	localparam logic [WAIT_W-1:0]  FIRST_WAIT_RST = 16'd200;
	localparam logic [WAIT_W-1:0]  STROKE_CAP_RST = 16'd2000;
	localparam logic [LIMIT_W-1:0] MISS_LIMIT_RST = 4'd3;

	// miss counter ceiling
	localparam logic [LIMIT_W-1:0] MISS_SAT = 4'd15;

endpackage

`default_nettype wire

FILE: src/touch_stroke_capture_core.sv
// Top level of the touch stroke capture core: input register, update logic, result register.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata poll fields, s_tuser opcode
//  m_       | out       | m_tvalid/m_tready  | m_tdata sample and stroke result
//  cfg_     | in        | cfg_wen            | cfg_idx register index, cfg_data value
//
//  One item is taken per cycle while the output is not stalled; each item gives exactly one result.
//  An item passes through the input register, then the result register.
//  s_tready drops only while both stages hold an item and m_tready is low.
//  Reset clears the stage valids, phase and miss count and loads the register defaults;
//  no clearing pass is needed, so items are taken from the first cycle after reset.
`default_nettype none

module touch_stroke_capture_core #(
	parameter int COORD_BITS = 12,
	localparam int IN_BITS = 34 + 2 * COORD_BITS,
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 19 + 6 * COORD_BITS,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// now_ms, read_ok, pressed, pos_x, pos_y, zero fill
	input  logic [IN_W-1:0]                s_tdata,
	// opcode
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// sample_valid, sample_x, sample_y, done_res, stroke_valid, start_x, start_y,
	// end_x, end_y, duration_ms, zero fill
	output logic [OUT_W-1:0]               m_tdata
);
	import tsc_pkg::*;

	localparam int CW    = COORD_BITS;
	localparam int OFS_OK = TIME_W;
	localparam int OFS_PR = TIME_W + 1;
	localparam int OFS_X  = TIME_W + 2;
	localparam int OFS_Y  = TIME_W + 2 + CW;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WAIT  = 2'd1,
		PH_TRACK = 2'd2
	} phase_t;

	// configuration registers
	logic [WAIT_W-1:0]  first_wait_q;
	logic [WAIT_W-1:0]  stroke_cap_q;
	logic [LIMIT_W-1:0] miss_limit_q;

	// input stage
	logic              valid_s1;
	opcode_t           op_s1;
	logic [TIME_W-1:0] now_s1;
	logic              ok_s1;
	logic              pr_s1;
	logic [CW-1:0]     x_s1;
	logic [CW-1:0]     y_s1;

	// capture state
	phase_t             phase_q;
	logic [TIME_W-1:0]  start_time_q;
	logic [TIME_W-1:0]  first_time_q;
	logic [CW-1:0]      first_x_q;
	logic [CW-1:0]      first_y_q;
	logic [CW-1:0]      last_x_q;
	logic [CW-1:0]      last_y_q;
	logic [LIMIT_W-1:0] miss_q;

	// result register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	// next state and result fields
	phase_t             phase_d;
	logic [TIME_W-1:0]  start_time_d;
	logic [TIME_W-1:0]  first_time_d;
	logic [CW-1:0]      first_x_d;
	logic [CW-1:0]      first_y_d;
	logic [CW-1:0]      last_x_d;
	logic [CW-1:0]      last_y_d;
	logic [LIMIT_W-1:0] miss_d;
	logic [TIME_W-1:0]  elapsed;
	logic [TIME_W-1:0]  dur_full;
	logic [DUR_W-1:0]   dur_sat;
	logic [LIMIT_W-1:0] miss_inc;
	logic               sample_v;
	logic [CW-1:0]      sample_x;
	logic [CW-1:0]      sample_y;
	logic               done;
	logic               stroke_v;
	logic [CW-1:0]      res_start_x;
	logic [CW-1:0]      res_start_y;
	logic [CW-1:0]      res_end_x;
	logic [CW-1:0]      res_end_y;
	logic [DUR_W-1:0]   res_dur;
	logic [OUT_W-1:0]   res_data;
	logic               advance;

	// move the input stage forward when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_wait_q <= FIRST_WAIT_RST;
			stroke_cap_q <= STROKE_CAP_RST;
			miss_limit_q <= MISS_LIMIT_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_FIRST_WAIT: first_wait_q <= cfg_data;
				CFG_STROKE_CAP: stroke_cap_q <= cfg_data;
				CFG_MISS_LIMIT: miss_limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// capture an input transaction
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= opcode_t'(s_tuser);
			now_s1 <= s_tdata[TIME_W-1:0];
			ok_s1  <= s_tdata[OFS_OK];
			pr_s1  <= s_tdata[OFS_PR];
			x_s1   <= s_tdata[OFS_X +: CW];
			y_s1   <= s_tdata[OFS_Y +: CW];
		end
	end

	// time since start and saturated stroke duration
	assign elapsed  = now_s1 - start_time_q;
	assign dur_full = now_s1 - first_time_q;
	assign dur_sat  = (|dur_full[TIME_W-1:DUR_W]) ? {DUR_W{1'b1}} : dur_full[DUR_W-1:0];
	assign miss_inc = (miss_q == MISS_SAT) ? miss_q : miss_q + LIMIT_W'(1);

	// per-item update of the capture state and the result fields
	always_comb begin
		phase_d      = phase_q;
		start_time_d = start_time_q;
		first_time_d = first_time_q;
		first_x_d    = first_x_q;
		first_y_d    = first_y_q;
		last_x_d     = last_x_q;
		last_y_d     = last_y_q;
		miss_d       = miss_q;
		sample_v     = 1'b0;
		sample_x     = '0;
		sample_y     = '0;
		done         = 1'b0;

		if (op_s1 == OP_START) begin
			phase_d      = PH_WAIT;
			start_time_d = now_s1;
			miss_d       = '0;
		end else begin
			case (phase_q)
				PH_WAIT: begin
					if (elapsed >= {{(TIME_W-WAIT_W){1'b0}}, first_wait_q}) begin
						done = 1'b1;
					end else if (ok_s1 && pr_s1) begin
						first_x_d    = x_s1;
						first_y_d    = y_s1;
						last_x_d     = x_s1;
						last_y_d     = y_s1;
						first_time_d = now_s1;
						miss_d       = '0;
						phase_d      = PH_TRACK;
						sample_v     = 1'b1;
						sample_x     = x_s1;
						sample_y     = y_s1;
					end
				end
				PH_TRACK: begin
					if (elapsed >= {{(TIME_W-WAIT_W){1'b0}}, stroke_cap_q}) begin
						done = 1'b1;
					end else if (ok_s1) begin
						if (pr_s1) begin
							last_x_d = x_s1;
							last_y_d = y_s1;
							miss_d   = '0;
							sample_v = 1'b1;
							sample_x = x_s1;
							sample_y = y_s1;
						end else begin
							miss_d = miss_inc;
							if (miss_inc >= miss_limit_q) begin
								done = 1'b1;
							end
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (done) begin
			phase_d = PH_IDLE;
		end
	end

	// stroke fields appear only when a tracked stroke ends
	assign stroke_v    = done && (phase_q == PH_TRACK);
	assign res_start_x = stroke_v ? first_x_q : '0;
	assign res_start_y = stroke_v ? first_y_q : '0;
	assign res_end_x   = stroke_v ? last_x_q : '0;
	assign res_end_y   = stroke_v ? last_y_q : '0;
	assign res_dur     = stroke_v ? dur_sat : '0;

	assign res_data = {{(OUT_W-OUT_BITS){1'b0}}, res_dur, res_end_y, res_end_x,
		res_start_y, res_start_x, stroke_v, done, sample_y, sample_x, sample_v};

	// capture control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			miss_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			miss_q  <= miss_d;
		end
	end

	// capture times and points
	always_ff @(posedge clk) begin
		if (advance) begin
			start_time_q <= start_time_d;
			first_time_q <= first_time_d;
			first_x_q    <= first_x_d;
			first_y_q    <= first_y_d;
			last_x_q     <= last_x_d;
			last_y_q     <= last_y_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// load the result
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res_data;
		end
	end

endmodule

`default_nettype wire

FILE: src/tsc_checker.sv
// Port-level checks for the touch stroke capture core and their bind.
`default_nettype none

`include "touch_stroke_capture_core_macros.svh"

module tsc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready
);

	// a stalled result stays offered
	`TSC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	// input backpressure only comes from a stalled result
	`TSC_ASSERT_NOW(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready, "input stalled without output stall")

	// an accepted item is followed by an offered result once it has passed the input and result registers
	`TSC_ASSERT_AFTER2(a_in_to_out, clk, arst_n, s_tvalid && s_tready, m_tvalid, "accepted item produced no result")

endmodule

bind touch_stroke_capture_core tsc_checker u_tsc_checker (.*);

`default_nettype wire
